// ===== sv/esc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and helper functions for the environment sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned IndexW = 3;
  localparam int unsigned CfgW   = 64;

  localparam logic [IndexW-1:0] RegTemperature = 3'd0;
  localparam logic [IndexW-1:0] RegPressureA   = 3'd1;
  localparam logic [IndexW-1:0] RegPressureB   = 3'd2;
  localparam logic [IndexW-1:0] RegHumidity    = 3'd3;
  localparam logic [IndexW-1:0] RegGasRange    = 3'd4;

  localparam logic [31:0] PresOffset   = 32'd64000;
  localparam logic [31:0] PresFull     = 32'd1048576;
  localparam logic [31:0] PresScale    = 32'd3125;
  localparam logic [31:0] PresUnity    = 32'd32768;
  localparam logic [31:0] TempRound    = 32'd128;
  localparam logic [31:0] TempScale    = 32'd5;
  localparam logic [31:0] HumUnity     = 32'd16384;
  localparam logic [31:0] HumScale     = 32'd1000;
  localparam logic [31:0] Recip100     = 32'h51EB851F;
  localparam logic [10:0] GasBase      = 11'd1340;
  localparam logic [10:0] GasErrScale  = 11'd5;
  localparam logic [27:0] GasOffset    = 28'd16777216;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
    logic [9:0]  raw_gas;
    logic [3:0]  gas_adc_range;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_pa;
    logic signed [31:0] humidity_milli;
    logic signed [31:0] gas_ohms;
    logic               divide_error;
  } result_t;

  // one restoring division lane: partial remainder, dividend/quotient shift, divisor
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] dvs;
  } div_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  // magnitude of x / 100, truncated; sign handled by caller
  function automatic logic [31:0] div100_mag(input logic [31:0] x);
    logic [31:0] m;
    logic [63:0] p;
    m = x[31] ? 32'(-x) : x;
    p = {32'd0, m} * {32'd0, Recip100};
    return {5'd0, p[63:37]};
  endfunction

  function automatic logic [31:0] gas_tab1(input logic [3:0] r);
    logic [31:0] v;
    case (r)
      4'd5, 4'd13: v = 32'd2126008810;
      4'd7:        v = 32'd2130303777;
      4'd10:       v = 32'd2143188679;
      4'd11:       v = 32'd2136746228;
      default:     v = 32'd2147483647;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] gas_tab2(input logic [3:0] r);
    logic [31:0] v;
    case (r)
      4'd0:    v = 32'd4096000000;
      4'd1:    v = 32'd2048000000;
      4'd2:    v = 32'd1024000000;
      4'd3:    v = 32'd512000000;
      4'd4:    v = 32'd255744255;
      4'd5:    v = 32'd127110228;
      4'd6:    v = 32'd64000000;
      4'd7:    v = 32'd32258064;
      4'd8:    v = 32'd16016016;
      4'd9:    v = 32'd8000000;
      4'd10:   v = 32'd4000000;
      4'd11:   v = 32'd2000000;
      4'd12:   v = 32'd1000000;
      4'd13:   v = 32'd500000;
      4'd14:   v = 32'd250000;
      default: v = 32'd125000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/esc_div_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc_div_step
// One restoring division step: shift in the next dividend bit, subtract the
// divisor when it fits, and shift the quotient bit in.
// ----------------------------------------------------------------------------
module esc_div_step (
  input  wire esc_pkg::div_t d,
  output esc_pkg::div_t      q
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {d.rem, d.num[31]};
  assign diff  = trial - {1'b0, d.dvs};
  assign fits  = trial >= {1'b0, d.dvs};

  assign q.rem = fits ? diff[31:0] : trial[31:0];
  assign q.num = {d.num[30:0], fits};
  assign q.dvs = d.dvs;

endmodule
`default_nettype wire

// ===== sv/environment_sensor_compensation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// environment_sensor_compensation
// Throughput: one sample per cycle while result_stall is low; the 32 radix-2
// division stages shared by pressure and gas set the depth, not the rate.
// Stages hold their item under stall and bubbles close up behind a stall.
// Reset clears all valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
module environment_sensor_compensation (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       write_enable,
  input  wire logic [esc_pkg::IndexW-1:0] write_index,
  input  wire logic [esc_pkg::CfgW-1:0]   write_data,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire esc_pkg::sample_t           sample,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output esc_pkg::result_t                result
);

  localparam int unsigned NStage    = 47;
  localparam int unsigned DivFirst  = 10;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned PostFirst = DivFirst + DivSteps;

  typedef struct packed {
    logic [19:0] rt;
    logic [19:0] rp;
    logic [15:0] rh;
    logic [9:0]  rg;
    logic [3:0]  gr;
    logic [25:0] g1;
    logic [27:0] g2;
    logic [48:0] g3;
    logic [49:0] gnum;
    logic        err;
    logic        pbig;
    logic        pneg;
    logic        hs3;
    logic        hs4;
    logic        hs5;
    logic        hs6;
    logic        hs7;
    esc_pkg::div_t pdv;
    esc_pkg::div_t gdv;
    logic [31:0] tv1;
    logic [31:0] tv2;
    logic [31:0] tq2;
    logic [31:0] tv3a;
    logic [31:0] tf;
    logic [31:0] tc;
    logic [31:0] pv1;
    logic [31:0] pqq;
    logic [31:0] pm5;
    logic [31:0] pm2;
    logic [31:0] pa;
    logic [31:0] pb;
    logic [31:0] pv2;
    logic [31:0] pv1b;
    logic [31:0] pv1c;
    logic [31:0] pca;
    logic [31:0] hm3;
    logic [31:0] hm4;
    logic [31:0] hm5;
    logic [31:0] hm7;
    logic [31:0] hq3;
    logic [31:0] hq4;
    logic [31:0] hq5;
    logic [31:0] hq7;
    logic [31:0] d3;
    logic [31:0] d4;
    logic [31:0] d5;
    logic [31:0] d7;
    logic [31:0] hx;
    logic [31:0] hq6;
    logic [31:0] d6;
    logic [31:0] hv1;
    logic [31:0] hv4;
    logic [31:0] hv2;
    logic [31:0] hv3;
    logic [31:0] hv5a;
    logic [31:0] hv6a;
    logic [31:0] hsum;
    logic [31:0] hum;
    logic [31:0] pc;
    logic [31:0] pv3m;
    logic [31:0] pv5a;
    logic [31:0] cc;
    logic [31:0] pv4a;
    logic [31:0] pv5;
    logic [31:0] ccc;
    logic [31:0] pv4;
    logic [31:0] v6a;
    logic [31:0] pfin;
  } ctx_t;

  function automatic ctx_t hum_work(input ctx_t c, input int unsigned j,
                                    input logic [31:0] h2v);
    ctx_t r;
    r = c;
    case (j)
      0: r.d6 = c.hs6 ? 32'(-c.hq6) : c.hq6;
      1: r.hv2 = esc_pkg::asr(esc_pkg::mul(h2v, c.d4 + c.d6 + esc_pkg::HumUnity), 10);
      2: r.hv3 = esc_pkg::mul(c.hv1, c.hv2);
      3: r.hv5a = esc_pkg::mul(esc_pkg::asr(c.hv3, 14), esc_pkg::asr(c.hv3, 14));
      4: r.hv6a = esc_pkg::mul(c.hv4, esc_pkg::asr(c.hv5a, 10));
      5: r.hsum = c.hv3 + esc_pkg::asr(c.hv6a, 1);
      6: r.hum = esc_pkg::asr(esc_pkg::mul(esc_pkg::asr(c.hsum, 10), esc_pkg::HumScale), 12);
      default: r = c;
    endcase
    return r;
  endfunction

  logic [39:0] temp_coeffs;
  logic [63:0] pres_coeffs_a;
  logic [63:0] pres_coeffs_b;
  logic [63:0] hum_coeffs;
  logic [3:0]  gas_range_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs   <= '0;
      pres_coeffs_a <= '0;
      pres_coeffs_b <= '0;
      hum_coeffs    <= '0;
      gas_range_err <= '0;
    end else if (write_enable) begin
      case (write_index)
        esc_pkg::RegTemperature: temp_coeffs   <= write_data[39:0];
        esc_pkg::RegPressureA:   pres_coeffs_a <= write_data;
        esc_pkg::RegPressureB:   pres_coeffs_b <= write_data;
        esc_pkg::RegHumidity:    hum_coeffs    <= write_data;
        esc_pkg::RegGasRange:    gas_range_err <= write_data[3:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3;
  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
  logic [31:0] h1, h2, h3, h4, h5, h6, h7;

  assign t1  = {16'd0, temp_coeffs[15:0]};
  assign t2  = esc_pkg::sx16(temp_coeffs[31:16]);
  assign t3  = esc_pkg::sx8(temp_coeffs[39:32]);
  assign p1  = {16'd0, pres_coeffs_a[15:0]};
  assign p2  = esc_pkg::sx16(pres_coeffs_a[31:16]);
  assign p3  = esc_pkg::sx8(pres_coeffs_a[39:32]);
  assign p4  = esc_pkg::sx16(pres_coeffs_a[55:40]);
  assign p6  = esc_pkg::sx8(pres_coeffs_a[63:56]);
  assign p5  = esc_pkg::sx16(pres_coeffs_b[15:0]);
  assign p7  = esc_pkg::sx8(pres_coeffs_b[23:16]);
  assign p8  = esc_pkg::sx16(pres_coeffs_b[39:24]);
  assign p9  = esc_pkg::sx16(pres_coeffs_b[55:40]);
  assign p10 = {24'd0, pres_coeffs_b[63:56]};
  assign h1  = {20'd0, hum_coeffs[11:0]};
  assign h2  = {20'd0, hum_coeffs[23:12]};
  assign h3  = esc_pkg::sx8(hum_coeffs[31:24]);
  assign h4  = esc_pkg::sx8(hum_coeffs[39:32]);
  assign h5  = esc_pkg::sx8(hum_coeffs[47:40]);
  assign h6  = {24'd0, hum_coeffs[55:48]};
  assign h7  = esc_pkg::sx8(hum_coeffs[63:56]);

  ctx_t pipe [NStage];
  ctx_t nxt  [NStage];
  logic vld  [NStage];
  logic rdy  [NStage+1];
  logic src_vld [NStage];

  assign rdy[NStage]  = !result_stall;
  assign sample_stall = !rdy[0];
  assign src_vld[0]   = sample_valid;

  for (genvar k = 0; k < NStage; k++) begin : g_ctl
    if (k > 0) begin : g_src
      assign src_vld[k] = vld[k-1];
    end
    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // stage 0: capture, temperature offset
  always_comb begin
    nxt[0]    = '0;
    nxt[0].rt = sample.raw_temperature;
    nxt[0].rp = sample.raw_pressure;
    nxt[0].rh = sample.raw_humidity;
    nxt[0].rg = sample.raw_gas;
    nxt[0].gr = sample.gas_adc_range;
    nxt[0].tv1 = {15'd0, sample.raw_temperature[19:3]} - (t1 << 1);
  end

  logic [10:0] gas_coef;
  logic [41:0] g1_prod;
  logic [57:0] g3_prod;

  assign gas_coef = esc_pkg::GasBase + 11'({{7{gas_range_err[3]}}, gas_range_err}
                                           * esc_pkg::GasErrScale);
  assign g1_prod  = {31'd0, gas_coef} * {10'd0, esc_pkg::gas_tab1(pipe[0].gr)};
  assign g3_prod  = {26'd0, esc_pkg::gas_tab2(pipe[1].gr)} * {32'd0, pipe[1].g1};

  always_comb begin
    nxt[1]     = pipe[0];
    nxt[1].tv2 = esc_pkg::asr(esc_pkg::mul(pipe[0].tv1, t2), 11);
    nxt[1].tq2 = esc_pkg::mul(esc_pkg::asr(pipe[0].tv1, 1), esc_pkg::asr(pipe[0].tv1, 1));
    nxt[1].g1  = g1_prod[41:16];
  end

  always_comb begin
    nxt[2]      = pipe[1];
    nxt[2].tv3a = esc_pkg::mul(esc_pkg::asr(pipe[1].tq2, 12), t3 << 4);
    nxt[2].g2   = 28'({pipe[1].rg, 15'd0}) + 28'(pipe[1].g1) - esc_pkg::GasOffset;
    nxt[2].g3   = g3_prod[57:9];
  end

  always_comb begin
    nxt[3]      = pipe[2];
    nxt[3].tf   = pipe[2].tv2 + esc_pkg::asr(pipe[2].tv3a, 14);
    nxt[3].gnum = 50'(pipe[2].g3) + 50'(pipe[2].g2[27:1]);
  end

  always_comb begin
    nxt[4]         = pipe[3];
    nxt[4].tc      = esc_pkg::asr(esc_pkg::mul(pipe[3].tf, esc_pkg::TempScale)
                                  + esc_pkg::TempRound, 8);
    nxt[4].pv1     = esc_pkg::asr(pipe[3].tf, 1) - esc_pkg::PresOffset;
    nxt[4].gdv.rem = {14'd0, pipe[3].gnum[49:32]};
    nxt[4].gdv.num = pipe[3].gnum[31:0];
    nxt[4].gdv.dvs = {4'd0, pipe[3].g2};
  end

  always_comb begin
    nxt[5]     = pipe[4];
    nxt[5].pqq = esc_pkg::mul(esc_pkg::asr(pipe[4].pv1, 2), esc_pkg::asr(pipe[4].pv1, 2));
    nxt[5].pm5 = esc_pkg::mul(pipe[4].pv1, p5);
    nxt[5].pm2 = esc_pkg::mul(p2, pipe[4].pv1);
    nxt[5].hm3 = esc_pkg::mul(pipe[4].tc, h3);
    nxt[5].hm4 = esc_pkg::mul(pipe[4].tc, h4);
    nxt[5].hm5 = esc_pkg::mul(pipe[4].tc, h5);
    nxt[5].hm7 = esc_pkg::mul(pipe[4].tc, h7);
  end

  always_comb begin
    nxt[6]     = pipe[5];
    nxt[6].pa  = esc_pkg::mul(esc_pkg::asr(pipe[5].pqq, 11), p6);
    nxt[6].pb  = esc_pkg::mul(esc_pkg::asr(pipe[5].pqq, 13), p3 << 5);
    nxt[6].hq3 = esc_pkg::div100_mag(pipe[5].hm3);
    nxt[6].hq4 = esc_pkg::div100_mag(pipe[5].hm4);
    nxt[6].hq5 = esc_pkg::div100_mag(pipe[5].hm5);
    nxt[6].hq7 = esc_pkg::div100_mag(pipe[5].hm7);
    nxt[6].hs3 = pipe[5].hm3[31];
    nxt[6].hs4 = pipe[5].hm4[31];
    nxt[6].hs5 = pipe[5].hm5[31];
    nxt[6].hs7 = pipe[5].hm7[31];
  end

  always_comb begin
    nxt[7]      = pipe[6];
    nxt[7].pv2  = esc_pkg::asr(esc_pkg::asr(pipe[6].pa, 2) + (pipe[6].pm5 << 1), 2)
                  + (p4 << 16);
    nxt[7].pv1b = esc_pkg::asr(esc_pkg::asr(pipe[6].pb, 3) + esc_pkg::asr(pipe[6].pm2, 1),
                               18);
    nxt[7].d3   = pipe[6].hs3 ? 32'(-pipe[6].hq3) : pipe[6].hq3;
    nxt[7].d4   = pipe[6].hs4 ? 32'(-pipe[6].hq4) : pipe[6].hq4;
    nxt[7].d5   = pipe[6].hs5 ? 32'(-pipe[6].hq5) : pipe[6].hq5;
    nxt[7].d7   = pipe[6].hs7 ? 32'(-pipe[6].hq7) : pipe[6].hq7;
  end

  always_comb begin
    nxt[8]      = pipe[7];
    nxt[8].pv1c = esc_pkg::asr(esc_pkg::mul(esc_pkg::PresUnity + pipe[7].pv1b, p1), 15);
    nxt[8].pca  = esc_pkg::mul(esc_pkg::PresFull - {12'd0, pipe[7].rp}
                               - esc_pkg::asr(pipe[7].pv2, 12), esc_pkg::PresScale);
    nxt[8].hx   = esc_pkg::mul(pipe[7].tc, pipe[7].d5);
    nxt[8].hv1  = {16'd0, pipe[7].rh} - (h1 << 4) - esc_pkg::asr(pipe[7].d3, 1);
    nxt[8].hv4  = esc_pkg::asr((h6 << 7) + pipe[7].d7, 4);
  end

  logic [31:0] pnum;

  assign pnum = (pipe[8].pca[31:30] == 2'b01) ? pipe[8].pca : (pipe[8].pca << 1);

  always_comb begin
    nxt[9]         = pipe[8];
    nxt[9].err     = pipe[8].pv1c == 32'd0;
    nxt[9].pbig    = pipe[8].pca[31:30] == 2'b01;
    nxt[9].pneg    = pnum[31] ^ pipe[8].pv1c[31];
    nxt[9].pdv.rem = '0;
    nxt[9].pdv.num = pnum[31] ? 32'(-pnum) : pnum;
    nxt[9].pdv.dvs = pipe[8].pv1c[31] ? 32'(-pipe[8].pv1c) : pipe[8].pv1c;
    nxt[9].hq6     = esc_pkg::div100_mag(esc_pkg::asr(pipe[8].hx, 6));
    nxt[9].hs6     = pipe[8].hx[31];
  end

  esc_pkg::div_t pstep [DivSteps];
  esc_pkg::div_t gstep [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    esc_div_step u_pdiv (
      .d (pipe[DivFirst+j-1].pdv),
      .q (pstep[j])
    );
    esc_div_step u_gdiv (
      .d (pipe[DivFirst+j-1].gdv),
      .q (gstep[j])
    );

    always_comb begin
      nxt[DivFirst+j]     = hum_work(pipe[DivFirst+j-1], j, h2);
      nxt[DivFirst+j].pdv = pstep[j];
      nxt[DivFirst+j].gdv = gstep[j];
    end
  end

  logic [31:0] pquo;

  assign pquo = pipe[PostFirst-1].pneg ? 32'(-pipe[PostFirst-1].pdv.num)
                                       : pipe[PostFirst-1].pdv.num;

  always_comb begin
    nxt[PostFirst]    = pipe[PostFirst-1];
    nxt[PostFirst].pc = pipe[PostFirst-1].pbig ? (pquo << 1) : pquo;
  end

  always_comb begin
    nxt[PostFirst+1]      = pipe[PostFirst];
    nxt[PostFirst+1].pv3m = esc_pkg::mul(esc_pkg::asr(pipe[PostFirst].pc, 3),
                                         esc_pkg::asr(pipe[PostFirst].pc, 3));
    nxt[PostFirst+1].pv5a = esc_pkg::mul(esc_pkg::asr(pipe[PostFirst].pc, 2), p8);
    nxt[PostFirst+1].cc   = esc_pkg::mul(esc_pkg::asr(pipe[PostFirst].pc, 8),
                                         esc_pkg::asr(pipe[PostFirst].pc, 8));
  end

  always_comb begin
    nxt[PostFirst+2]      = pipe[PostFirst+1];
    nxt[PostFirst+2].pv4a = esc_pkg::mul(p9, esc_pkg::asr(pipe[PostFirst+1].pv3m, 13));
    nxt[PostFirst+2].pv5  = esc_pkg::asr(pipe[PostFirst+1].pv5a, 13);
    nxt[PostFirst+2].ccc  = esc_pkg::mul(pipe[PostFirst+1].cc,
                                         esc_pkg::asr(pipe[PostFirst+1].pc, 8));
  end

  always_comb begin
    nxt[PostFirst+3]     = pipe[PostFirst+2];
    nxt[PostFirst+3].pv4 = esc_pkg::asr(pipe[PostFirst+2].pv4a, 12);
    nxt[PostFirst+3].v6a = esc_pkg::mul(pipe[PostFirst+2].ccc, p10);
  end

  always_comb begin
    nxt[PostFirst+4]      = pipe[PostFirst+3];
    nxt[PostFirst+4].pfin = pipe[PostFirst+3].err ? 32'd0 :
        pipe[PostFirst+3].pc + esc_pkg::asr(pipe[PostFirst+3].pv4 + pipe[PostFirst+3].pv5
        + esc_pkg::asr(pipe[PostFirst+3].v6a, 17) + (p7 << 7), 4);
  end

  assign result_valid             = vld[NStage-1];
  assign result.temperature_centi = pipe[NStage-1].tc;
  assign result.pressure_pa       = pipe[NStage-1].pfin;
  assign result.humidity_milli    = pipe[NStage-1].hum;
  assign result.gas_ohms          = pipe[NStage-1].gdv.num;
  assign result.divide_error      = pipe[NStage-1].err;

endmodule
`default_nettype wire
